// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLKD(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define ASSERT_NORST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) else $error("assertion failed");
`else
`define ASSERT_CLKD(lbl, prop)
`define ASSERT_NORST(lbl, prop)
`endif
`endif

// ===== sv/ftfc_pkg.sv =====
// Types, constants and the CRC step of the file transfer frame checker.
package ftfc_pkg;

  localparam int unsigned HS_LEN = 7;

  localparam logic [15:0] CRC_POLY     = 16'h1021;
  localparam logic [7:0]  INFO_SEQ     = 8'h5A;
  localparam logic [7:0]  INFO_SEQ_INV = 8'hA5;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_HEAD = 2'd1;
  localparam logic [1:0] ST_BAD_SEQ = 2'd2;
  localparam logic [1:0] ST_BAD_CRC = 2'd3;

  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_INFO = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;

  localparam logic CFG_SHORT_CODE = 1'b0;
  localparam logic CFG_LONG_CODE  = 1'b1;

  typedef struct packed {
    logic [1:0] status;
    logic [1:0] phase;
    logic       frame_good;
    logic [7:0] frame_seq;
    logic       frame_long;
  } result_t;

  // Handshake text "ISREADY"
  function automatic logic [7:0] hs_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0: c = 8'h49;
      3'd1: c = 8'h53;
      3'd2: c = 8'h52;
      3'd3: c = 8'h45;
      3'd4: c = 8'h41;
      3'd5: c = 8'h44;
      3'd6: c = 8'h59;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // CRC-16/XMODEM, one byte, MSB first
  function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ===== sv/ftfc_in_stage.sv =====
// Input register stage holding one received byte.
module ftfc_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_i,
  input  logic       pop_i,
  output logic       valid_o,
  output logic [7:0] data_o
);

  logic       valid_q, valid_d;
  logic [7:0] data_q;
  logic       take;

  assign in_ready_o = !valid_q || pop_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (pop_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== sv/ftfc_core.sv =====
// Receiver state, type code registers and the per-byte step logic.
module ftfc_core #(
  parameter int unsigned HeaderBytes  = 4,
  parameter int unsigned ShortPayload = 128,
  parameter int unsigned LongPayload  = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [7:0]            cfg_wdata_i,
  input  logic                  step_i,
  input  logic [7:0]            data_i,
  output ftfc_pkg::result_t     res_o
);

  localparam int unsigned PayMax = (ShortPayload > LongPayload) ? ShortPayload : LongPayload;
  localparam int unsigned CntW   = $clog2(HeaderBytes + PayMax + 2);

  localparam logic [CntW-1:0] PosSeq    = CntW'(2);
  localparam logic [CntW-1:0] PosSeqInv = CntW'(3);
  localparam logic [CntW-1:0] PosPay    = CntW'(HeaderBytes);
  localparam logic [CntW-1:0] ShortEnd  = CntW'(HeaderBytes + ShortPayload);
  localparam logic [CntW-1:0] LongEnd   = CntW'(HeaderBytes + LongPayload);
  localparam logic [CntW-1:0] ShortLast = CntW'(HeaderBytes + ShortPayload + 1);
  localparam logic [CntW-1:0] LongLast  = CntW'(HeaderBytes + LongPayload + 1);
  localparam logic [CntW-1:0] HsLen     = CntW'(ftfc_pkg::HS_LEN);

  logic [7:0]      short_code_q, long_code_q;
  logic [1:0]      phase_q, phase_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            long_q, long_d;
  logic [7:0]      last_seq_q, last_seq_d;
  logic [7:0]      seq_q, seq_d;
  logic [7:0]      seq_inv_q, seq_inv_d;
  logic [15:0]     crc_q, crc_d;
  logic [7:0]      crc_hi_q, crc_hi_d;

  logic [1:0]      status;
  logic            good;
  logic            info;
  logic [15:0]     crc_cur;
  logic [CntW-1:0] pay_end, last_pos;
  logic [7:0]      want, want_inv;
  logic [2:0]      m;

  always_comb begin
    phase_d    = phase_q;
    cnt_d      = cnt_q;
    long_d     = long_q;
    last_seq_d = last_seq_q;
    seq_d      = seq_q;
    seq_inv_d  = seq_inv_q;
    crc_d      = crc_q;
    crc_hi_d   = crc_hi_q;
    status     = ftfc_pkg::ST_OK;
    good       = 1'b0;
    info       = (phase_q == ftfc_pkg::PH_INFO);
    crc_cur    = crc_q;
    pay_end    = ShortEnd;
    last_pos   = ShortLast;
    want       = info ? ftfc_pkg::INFO_SEQ : last_seq_q + 8'd1;
    want_inv   = info ? ftfc_pkg::INFO_SEQ_INV : ~(last_seq_q + 8'd1);
    m          = (cnt_q < HsLen) ? cnt_q[2:0] : 3'd0;

    if (phase_q == ftfc_pkg::PH_INFO || phase_q == ftfc_pkg::PH_DATA) begin
      if (cnt_q == '0) begin
        crc_cur = '0;
        if (info) begin
          if (data_i != short_code_q) begin
            status = ftfc_pkg::ST_BAD_HEAD;
          end else begin
            long_d = 1'b0;
          end
        end else if (data_i == short_code_q) begin
          long_d = 1'b0;
        end else if (data_i == long_code_q) begin
          long_d = 1'b1;
        end else begin
          status = ftfc_pkg::ST_BAD_HEAD;
        end
      end
      pay_end  = long_d ? LongEnd : ShortEnd;
      last_pos = long_d ? LongLast : ShortLast;
      crc_d    = crc_cur;

      if (status == ftfc_pkg::ST_OK) begin
        if (cnt_q == PosSeq) begin
          seq_d = data_i;
        end else if (cnt_q == PosSeqInv) begin
          seq_inv_d = data_i;
        end else if (cnt_q >= PosPay && cnt_q < pay_end) begin
          crc_d = ftfc_pkg::crc_add(crc_cur, data_i);
        end else if (cnt_q == pay_end) begin
          crc_hi_d = data_i;
        end

        if (cnt_q >= last_pos) begin
          if (seq_q != want || seq_inv_q != want_inv) begin
            status = ftfc_pkg::ST_BAD_SEQ;
          end else if ({crc_hi_q, data_i} != crc_d) begin
            status = ftfc_pkg::ST_BAD_CRC;
          end else begin
            good  = 1'b1;
            cnt_d = '0;
            if (info) begin
              phase_d = ftfc_pkg::PH_DATA;
            end else begin
              last_seq_d = seq_q;
            end
          end
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
      end

      if (status != ftfc_pkg::ST_OK) begin
        phase_d    = ftfc_pkg::PH_HUNT;
        cnt_d      = '0;
        long_d     = 1'b0;
        last_seq_d = '0;
        seq_d      = '0;
        seq_inv_d  = '0;
        crc_d      = '0;
        crc_hi_d   = '0;
      end
    end else begin
      phase_d = ftfc_pkg::PH_HUNT;
      if (data_i != ftfc_pkg::hs_char(m)) begin
        cnt_d = (data_i == ftfc_pkg::hs_char(3'd0)) ? CntW'(1) : '0;
      end else if (CntW'(m) + CntW'(1) < HsLen) begin
        cnt_d = CntW'(m) + CntW'(1);
      end else begin
        cnt_d   = '0;
        phase_d = ftfc_pkg::PH_INFO;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_code_q <= 8'd1;
      long_code_q  <= 8'd2;
      phase_q      <= ftfc_pkg::PH_HUNT;
      cnt_q        <= '0;
      long_q       <= 1'b0;
      last_seq_q   <= '0;
      seq_q        <= '0;
      seq_inv_q    <= '0;
      crc_q        <= '0;
      crc_hi_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == ftfc_pkg::CFG_SHORT_CODE) begin
          short_code_q <= cfg_wdata_i;
        end else begin
          long_code_q <= cfg_wdata_i;
        end
      end
      if (step_i) begin
        phase_q    <= phase_d;
        cnt_q      <= cnt_d;
        long_q     <= long_d;
        last_seq_q <= last_seq_d;
        seq_q      <= seq_d;
        seq_inv_q  <= seq_inv_d;
        crc_q      <= crc_d;
        crc_hi_q   <= crc_hi_d;
      end
    end
  end

  assign res_o.status     = status;
  assign res_o.phase      = phase_d;
  assign res_o.frame_good = good;
  assign res_o.frame_seq  = last_seq_d;
  assign res_o.frame_long = long_d;

endmodule

// ===== sv/ftfc_out_stage.sv =====
// Result register stage towards the receiver.
module ftfc_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  ftfc_pkg::result_t res_i,
  input  logic              out_ready_i,
  output logic              space_o,
  output logic              valid_o,
  output ftfc_pkg::result_t res_o
);

  logic              valid_q, valid_d;
  ftfc_pkg::result_t res_q;

  assign space_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ===== sv/file_transfer_frame_checker.sv =====
// Top level of the file transfer frame checker.
// Usage:
//   Input channel: one received byte per request on data_byte_i, handshaked
//   by in_valid_i / in_ready_o. Output channel: one status result per byte
//   (status, phase, frame_good, frame_seq, frame_long) on out_valid_o /
//   out_ready_i.
//   Path: a byte accepted into the input register is stepped into the result
//   register when the output stage has space, then shows on out_valid_o.
//   Throughput: one byte per cycle unless out_ready_i stalls; the step logic
//   (CRC byte update and counter compares) sits between the input and result registers.
//   Type codes are written through cfg_we_i / cfg_idx_i / cfg_wdata_i while
//   the block is idle; index 0 is the short frame code, index 1 the long one.
//   Reset: both stages empty, receiver hunting for the handshake, codes 1
//   and 2.
//   Receiver stall: the result register holds; the input register still
//   takes one more byte, then in_ready_o drops until the result is taken.
`include "assert_macros.svh"
module file_transfer_frame_checker #(
  parameter int unsigned HEADER_BYTES  = 4,
  parameter int unsigned SHORT_PAYLOAD = 128,
  parameter int unsigned LONG_PAYLOAD  = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] status_o,
  output logic [1:0] phase_o,
  output logic       frame_good_o,
  output logic [7:0] frame_seq_o,
  output logic       frame_long_o,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [7:0] cfg_wdata_i
);

  logic              byte_valid;
  logic [7:0]        byte_q;
  logic              space;
  logic              step;
  ftfc_pkg::result_t res_d;
  ftfc_pkg::result_t res_q;
  logic              res_err;
  logic              res_clear;
  logic              res_good;
  logic              res_good_ok;

  assign step = byte_valid && space;

  ftfc_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .data_i     (data_byte_i),
    .pop_i      (step),
    .valid_o    (byte_valid),
    .data_o     (byte_q)
  );

  ftfc_core #(
    .HeaderBytes  (HEADER_BYTES),
    .ShortPayload (SHORT_PAYLOAD),
    .LongPayload  (LONG_PAYLOAD)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (step),
    .data_i      (byte_q),
    .res_o       (res_d)
  );

  ftfc_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .res_i       (res_d),
    .out_ready_i (out_ready_i),
    .space_o     (space),
    .valid_o     (out_valid_o),
    .res_o       (res_q)
  );

  assign status_o     = res_q.status;
  assign phase_o      = res_q.phase;
  assign frame_good_o = res_q.frame_good;
  assign frame_seq_o  = res_q.frame_seq;
  assign frame_long_o = res_q.frame_long;

  assign res_err     = out_valid_o && (status_o != ftfc_pkg::ST_OK);
  assign res_clear   = (phase_o == ftfc_pkg::PH_HUNT) && !frame_long_o && (frame_seq_o == 8'd0);
  assign res_good    = out_valid_o && frame_good_o;
  assign res_good_ok = (status_o == ftfc_pkg::ST_OK) && (phase_o == ftfc_pkg::PH_DATA);

  `ASSERT_CLKD(a_err_clears, res_err |-> res_clear)
  `ASSERT_CLKD(a_good_ok, res_good |-> res_good_ok)
  `ASSERT_CLKD(a_phase_legal, out_valid_o |-> (phase_o != 2'd3))
  `ASSERT_CLKD(a_stall_only, (!in_ready_o) |-> (out_valid_o && !out_ready_i && byte_valid))
  `ASSERT_NORST(a_reset_empty, (!rst_ni) |-> (!out_valid_o && in_ready_o))

endmodule
